### src/lzd_pkg.sv
// Package for the LZ descriptor bitfield decompressor.
// Holds the shared constants, payload structs, command format and state enums.
`timescale 1ns / 1ps
`default_nettype none
package lzd_pkg;

  localparam int unsigned WINDOW_DEPTH = 8192;
  localparam int unsigned OUT_LANES    = 8;
  localparam int unsigned WIN_AW       = $clog2(WINDOW_DEPTH);
  localparam int unsigned LANE_IDX_W   = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1;
  localparam int unsigned CNT_W        = 9;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QUEUE_AW     = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] LIMIT_RESET  = 16'hFFFF;
  localparam logic [15:0] SHORT_BASE   = 16'hFF00;
  localparam logic [2:0]  INL_LEN_MASK = 3'h7;
  localparam logic [4:0]  DESC_BITS    = 5'd16;

  localparam logic [1:0]  ST_RUN   = 2'd0;
  localparam logic [1:0]  ST_END   = 2'd1;
  localparam logic [1:0]  ST_LIMIT = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_req;
  } lzd_in_t;

  typedef struct packed {
    logic [63:0] out_data;
    logic [3:0]  out_count;
    logic        last;
    logic [1:0]  status;
  } lzd_out_t;

  typedef enum logic [3:0] {
    PH_TOKEN     = 4'd0,
    PH_FLAG2     = 4'd1,
    PH_SC1       = 4'd2,
    PH_SC2_0     = 4'd3,
    PH_SC2_1     = 4'd4,
    PH_LITERAL   = 4'd5,
    PH_SHORT_OFF = 4'd6,
    PH_INL_LO    = 4'd7,
    PH_INL_HI    = 4'd8,
    PH_EXT_CNT   = 4'd9,
    PH_DESC_LO   = 4'd10,
    PH_DESC_HI   = 4'd11,
    PH_STOPPED   = 4'd12
  } lzd_phase_e;

  typedef enum logic [1:0] {
    CK_NONE = 2'd0,
    CK_LIT  = 2'd1,
    CK_COPY = 2'd2,
    CK_END  = 2'd3
  } lzd_kind_e;

  typedef struct packed {
    lzd_kind_e        kind;
    logic             start;
    logic [7:0]       lit;
    logic [15:0]      offset;
    logic [CNT_W-1:0] count;
  } lzd_cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_READ  = 2'd1,
    BK_WRITE = 2'd2
  } lzd_back_e;

endpackage
`default_nettype wire

### src/lzd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lzd_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DATA_W-1:0]        wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### src/lzd_front.sv
// Front end: parses compressed bytes, tracks the descriptor and emits commands.
// Depends on lzd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lzd_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire lzd_pkg::lzd_in_t in_i,
  input  wire logic            accept_i,
  output lzd_pkg::lzd_cmd_t    cmd_o,
  output logic                 cmd_valid_o
);
  import lzd_pkg::*;

  lzd_phase_e  phase_q, phase_d;
  logic [15:0] desc_q, desc_d;
  logic [4:0]  bits_q, bits_d;
  logic [7:0]  off_lo_q, off_lo_d;
  logic [7:0]  off_hi_q, off_hi_d;

  always_comb begin
    lzd_phase_e ph, nx;
    logic [15:0] desc;
    logic [4:0]  bits;
    logic [7:0]  lo, hi, b;
    logic        run, done, bit_v;
    lzd_cmd_t    cmd;

    b    = in_i.in_byte;
    ph   = phase_q;
    desc = desc_q;
    bits = bits_q;
    lo   = off_lo_q;
    hi   = off_hi_q;
    run  = 1'b0;
    done = 1'b0;
    nx   = PH_TOKEN;
    bit_v = 1'b0;
    cmd  = '{kind: CK_NONE, start: in_i.start_req, lit: b, offset: '0, count: '0};

    if (in_i.start_req) begin
      desc = '0;
      bits = '0;
      lo   = '0;
      hi   = '0;
      ph   = PH_DESC_LO;
    end

    case (ph)
      PH_DESC_LO: begin
        desc = {8'h00, b};
        ph   = PH_DESC_HI;
      end
      PH_DESC_HI: begin
        desc = {b, desc[7:0]};
        bits = DESC_BITS;
        ph   = (hi <= 8'(PH_INL_LO)) ? lzd_phase_e'(hi[3:0]) : PH_TOKEN;
        run  = 1'b1;
      end
      PH_LITERAL: begin
        cmd.kind = CK_LIT;
        ph  = PH_TOKEN;
        run = 1'b1;
      end
      PH_SHORT_OFF: begin
        cmd.kind   = CK_COPY;
        cmd.offset = SHORT_BASE | {8'h00, b};
        cmd.count  = CNT_W'(lo);
        ph  = PH_TOKEN;
        run = 1'b1;
      end
      PH_INL_LO: begin
        lo = b;
        ph = PH_INL_HI;
      end
      PH_INL_HI: begin
        hi = b;
        if ((b[2:0] & INL_LEN_MASK) != 3'd0) begin
          cmd.kind   = CK_COPY;
          cmd.offset = {3'b111, b[7:3], lo};
          cmd.count  = CNT_W'(b[2:0]) + CNT_W'(2);
          ph  = PH_TOKEN;
          run = 1'b1;
        end else begin
          ph = PH_EXT_CNT;
        end
      end
      PH_EXT_CNT: begin
        if (b == 8'd0) begin
          cmd.kind = CK_END;
          ph = PH_STOPPED;
        end else begin
          if (b != 8'd1) begin
            cmd.kind   = CK_COPY;
            cmd.offset = {3'b111, hi[7:3], lo};
            cmd.count  = CNT_W'(b) + CNT_W'(1);
          end
          ph  = PH_TOKEN;
          run = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // At most four descriptor bits are taken before a byte is needed.
    if (run) begin
      for (int i = 0; i < 4; i++) begin
        if (!done && ph <= PH_SC2_1) begin
          if (bits == 5'd0) begin
            hi   = 8'(ph);
            ph   = PH_DESC_LO;
            done = 1'b1;
          end else begin
            bit_v = desc[0];
            desc  = desc >> 1;
            bits  = bits - 5'd1;
            case (ph)
              PH_TOKEN: nx = bit_v ? PH_LITERAL : PH_FLAG2;
              PH_FLAG2: nx = bit_v ? PH_INL_LO : PH_SC1;
              PH_SC1:   nx = bit_v ? PH_SC2_1 : PH_SC2_0;
              PH_SC2_0: begin
                lo = bit_v ? 8'd3 : 8'd2;
                nx = PH_SHORT_OFF;
              end
              default: begin
                lo = bit_v ? 8'd5 : 8'd4;
                nx = PH_SHORT_OFF;
              end
            endcase
            if (bits == 5'd0) begin
              hi   = 8'(nx);
              ph   = PH_DESC_LO;
              done = 1'b1;
            end else begin
              ph = nx;
            end
          end
        end
      end
    end

    phase_d     = ph;
    desc_d      = desc;
    bits_d      = bits;
    off_lo_d    = lo;
    off_hi_d    = hi;
    cmd_o       = cmd;
    cmd_valid_o = (cmd.kind != CK_NONE) || cmd.start;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_DESC_LO;
      desc_q   <= '0;
      bits_q   <= '0;
      off_lo_q <= '0;
      off_hi_q <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      desc_q   <= desc_d;
      bits_q   <= bits_d;
      off_lo_q <= off_lo_d;
      off_hi_q <= off_hi_d;
    end
  end

endmodule
`default_nettype wire

### src/lzd_cmd_queue.sv
// Small command queue between the front end and the back end.
// Depends on lzd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lzd_cmd_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wr_i,
  input  wire lzd_pkg::lzd_cmd_t wdata_i,
  output logic                   full_o,
  input  wire logic              rd_i,
  output lzd_pkg::lzd_cmd_t      rdata_o,
  output logic                   valid_o
);
  import lzd_pkg::*;

  lzd_cmd_t            slot_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr_q, rptr_q;
  logic [QUEUE_AW:0]   cnt_q;
  logic                do_wr, do_rd;

  assign full_o  = (cnt_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = slot_q[rptr_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### src/lzd_back.sv
// Back end: executes commands against the history window and packs output bytes.
// Depends on lzd_pkg and lzd_ram.
`timescale 1ns / 1ps
`default_nettype none
module lzd_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [15:0]       limit_i,
  input  wire lzd_pkg::lzd_cmd_t cmd_i,
  input  wire logic              cmd_valid_i,
  output logic                   cmd_pop_o,
  output lzd_pkg::lzd_out_t      res_o,
  output logic                   res_valid_o,
  input  wire logic              res_pop_i
);
  import lzd_pkg::*;

  lzd_back_e        state_q, state_d;
  logic [15:0]      pos_q, pos_d;
  logic             stop_q, stop_d;
  logic [3:0]       lanes_q, lanes_d;
  logic [63:0]      pack_q, pack_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [15:0]      off_q, off_d;
  lzd_out_t         res_q, res_d;
  logic             rv_q, rv_d;

  logic             ram_we, ram_re;
  logic [7:0]       ram_rdata, pb;
  logic [15:0]      src, npos;
  logic [3:0]       nl;
  logic [63:0]      ndata;
  logic             lim, fin, flush, out_free;
  lzd_out_t         put_res;

  lzd_ram #(.DATA_W(8), .DEPTH(WINDOW_DEPTH)) u_hist (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(pos_q[WIN_AW-1:0]),
    .wdata_i(pb),
    .re_i   (ram_re),
    .raddr_i(src[WIN_AW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign src      = pos_q + off_q;
  assign out_free = !rv_q || res_pop_i;

  // Byte placement shared by literals and copies.
  always_comb begin
    pb    = (state_q == BK_WRITE) ? ram_rdata : cmd_i.lit;
    fin   = (state_q == BK_WRITE) ? (cnt_q == CNT_W'(1)) : 1'b1;
    nl    = lanes_q + 4'd1;
    npos  = pos_q + 16'd1;
    ndata = pack_q | (64'(pb) << {lanes_q[LANE_IDX_W-1:0], 3'b000});
    lim   = (npos >= limit_i);
    flush = lim || (nl == 4'(OUT_LANES)) || fin;
    put_res.out_data  = ndata;
    put_res.out_count = nl;
    put_res.last      = lim || fin;
    put_res.status    = lim ? ST_LIMIT : ST_RUN;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && !cmd_i.start && !stop_q && cmd_i.kind == CK_COPY) begin
          state_d = BK_READ;
        end
      end
      BK_READ: state_d = BK_WRITE;
      BK_WRITE: begin
        if (!flush || out_free) begin
          state_d = (lim || fin) ? BK_IDLE : BK_READ;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    pos_d     = pos_q;
    stop_d    = stop_q;
    lanes_d   = lanes_q;
    pack_d    = pack_q;
    cnt_d     = cnt_q;
    off_d     = off_q;
    res_d     = res_q;
    rv_d      = rv_q && !res_pop_i;
    cmd_pop_o = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.start) begin
            cmd_pop_o = 1'b1;
            pos_d     = '0;
            stop_d    = 1'b0;
          end else if (stop_q) begin
            cmd_pop_o = 1'b1;
          end else begin
            case (cmd_i.kind)
              CK_LIT: begin
                if (out_free) begin
                  cmd_pop_o = 1'b1;
                  ram_we    = 1'b1;
                  pos_d     = npos;
                  lanes_d   = '0;
                  pack_d    = '0;
                  res_d     = put_res;
                  rv_d      = 1'b1;
                  stop_d    = lim;
                end
              end
              CK_COPY: begin
                cmd_pop_o = 1'b1;
                off_d     = cmd_i.offset;
                cnt_d     = cmd_i.count;
              end
              CK_END: begin
                if (out_free) begin
                  cmd_pop_o = 1'b1;
                  res_d     = '{out_data: '0, out_count: '0, last: 1'b1, status: ST_END};
                  rv_d      = 1'b1;
                  stop_d    = 1'b1;
                end
              end
              default: cmd_pop_o = 1'b1;
            endcase
          end
        end
      end
      BK_READ: ram_re = 1'b1;
      BK_WRITE: begin
        if (!flush || out_free) begin
          ram_we = 1'b1;
          pos_d  = npos;
          cnt_d  = cnt_q - CNT_W'(1);
          stop_d = lim;
          if (flush) begin
            lanes_d = '0;
            pack_d  = '0;
            res_d   = put_res;
            rv_d    = 1'b1;
          end else begin
            lanes_d = nl;
            pack_d  = ndata;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      pos_q   <= '0;
      stop_q  <= 1'b0;
      lanes_q <= '0;
      pack_q  <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      stop_q  <= stop_d;
      lanes_q <= lanes_d;
      pack_q  <= pack_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    off_q <= off_d;
    res_q <= res_d;
  end

  assign res_o       = res_q;
  assign res_valid_o = rv_q;

endmodule
`default_nettype wire

### src/lz_descriptor_bitfield_decompressor.sv
// Kosinski-style LZ decompressor with a descriptor bitfield.
// Compressed bytes are written like a queue: drive in_i and push; the byte is
// taken at an edge where push is high and full is low. Set start_req on the
// first byte of every stream. Results are read like a queue: while empty is
// low, res_o holds the oldest result (up to eight bytes, earliest in the low
// lane), removed by pop at an edge where empty is low.
// The front end parses one byte per cycle, while the command queue has room,
// into a four-entry command queue. The back end executes commands: a literal
// or end marker is output from the idle state; a copy loads its offset and
// count there, then does one history RAM read and one write per byte. A
// stalled receiver holds the single output register, which stalls the back
// end; the front end keeps taking bytes until the command queue fills. A
// literal's result reaches res_o through the command queue and output register.
// The output limit is written on the cfg channel, which is always ready;
// write it only while idle. Reset clears all control state and sets the
// limit to 65535; the history RAM is not cleared.
// Depends on lzd_pkg, lzd_front, lzd_cmd_queue and lzd_back.
`timescale 1ns / 1ps
`default_nettype none
module lz_descriptor_bitfield_decompressor (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire lzd_pkg::lzd_in_t  in_i,
  input  wire logic              push,
  output logic                   full,
  output lzd_pkg::lzd_out_t      res_o,
  output logic                   empty,
  input  wire logic              pop,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [15:0]       cfg_data_i
);
  import lzd_pkg::*;

  logic [15:0] limit_q;
  lzd_cmd_t    f_cmd, q_cmd;
  logic        f_cmd_valid, q_valid, q_pop, q_full, accept, res_valid;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;
  assign accept      = push && !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  lzd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .accept_i   (accept),
    .cmd_o      (f_cmd),
    .cmd_valid_o(f_cmd_valid)
  );

  lzd_cmd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (accept && f_cmd_valid),
    .wdata_i(f_cmd),
    .full_o (q_full),
    .rd_i   (q_pop),
    .rdata_o(q_cmd),
    .valid_o(q_valid)
  );

  lzd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .limit_i    (limit_q),
    .cmd_i      (q_cmd),
    .cmd_valid_i(q_valid),
    .cmd_pop_o  (q_pop),
    .res_o      (res_o),
    .res_valid_o(res_valid),
    .res_pop_i  (pop)
  );

  assign empty = !res_valid;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> res_o.out_count <= 4'(OUT_LANES))
    else $error("result lane count out of range");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_o.status != ST_RUN) |-> res_o.last)
    else $error("terminal status without last");

  a_end_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_o.status == ST_END) |-> res_o.out_count == 4'd0)
    else $error("end marker carries data");

  a_no_zero_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && res_o.status == ST_RUN) |-> res_o.out_count != 4'd0)
    else $error("empty running result");

endmodule
`default_nettype wire
